>>> hdl/ubt_pkg.sv
// Shared types, constants and helper functions for the base-text converter.
package ubt_pkg;

  localparam int VALUE_BITS = 48;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CNT_W      = 6;
  localparam int CHAR_W     = 8;
  localparam int TIDX_W     = 3;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 64;
  localparam int ALPHA_W    = 128;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_RADIX    = 2'd0;
  localparam logic [1:0] REG_CHARS_LO = 2'd1;
  localparam logic [1:0] REG_CHARS_HI = 2'd2;

  localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LPAR = 8'h28;
  localparam logic [CHAR_W-1:0] CH_N    = 8'h6e;
  localparam logic [CHAR_W-1:0] CH_I    = 8'h69;
  localparam logic [CHAR_W-1:0] CH_L    = 8'h6c;
  localparam logic [CHAR_W-1:0] CH_RPAR = 8'h29;
  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;

  localparam logic [TIDX_W-1:0] NIL_LAST = TIDX_W'(4);
  localparam logic [TIDX_W-1:0] PFX_LAST = TIDX_W'(1);

  typedef enum logic [1:0] {
    K_ZERO,
    K_NIL,
    K_BAD,
    K_CONV
  } ubt_kind_t;

  typedef struct packed {
    ubt_kind_t               kind;
    logic                    ptr;
    logic [RADIX_W-1:0]      radix;
    logic [VALUE_BITS-1:0]   value;
  } ubt_entry_t;

  typedef struct packed {
    logic                    start;
    logic [VALUE_BITS-1:0]   dividend;
    logic [RADIX_W-1:0]      divisor;
  } ubt_div_req_t;

  typedef struct packed {
    logic                    done;
    logic [VALUE_BITS-1:0]   quot;
    logic [DIGIT_W-1:0]      rem;
  } ubt_div_res_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_TEXT,
    B_DIV,
    B_PFX,
    B_RD,
    B_OUT
  } ubt_bstate_t;

  // characters of the fixed texts ("0", "(nil)", error)
  function automatic logic [CHAR_W-1:0] fixed_char(ubt_kind_t kind, logic [TIDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = CH_NUL;
    case (kind)
      K_ZERO: c = CH_ZERO;
      K_NIL: begin
        case (idx)
          3'd0:    c = CH_LPAR;
          3'd1:    c = CH_N;
          3'd2:    c = CH_I;
          3'd3:    c = CH_L;
          default: c = CH_RPAR;
        endcase
      end
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic fixed_last(ubt_kind_t kind, logic [TIDX_W-1:0] idx);
    logic l;
    l = 1'b1;
    case (kind)
      K_NIL:   l = (idx == NIL_LAST);
      default: l = 1'b1;
    endcase
    return l;
  endfunction

endpackage

>>> hdl/ubt_queue.sv
// Two-entry request queue between the front and back ends.
module ubt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ubt_pkg::ubt_entry_t din,
  output logic                full,
  input  logic                pop,
  output logic                nonempty,
  output ubt_pkg::ubt_entry_t dout
);

  ubt_pkg::ubt_entry_t mem_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          count_r;

  assign full     = (count_r == 2'd2);
  assign nonempty = (count_r != 2'd0);
  assign dout     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hdl/ubt_div.sv
// Bit-serial restoring divider: wide value by a small radix, one bit a cycle.
module ubt_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ubt_pkg::ubt_div_req_t req,
  output ubt_pkg::ubt_div_res_t res
);

  localparam int VB = ubt_pkg::VALUE_BITS;
  localparam int RW = ubt_pkg::RADIX_W;
  localparam int DW = ubt_pkg::DIGIT_W;
  localparam int CW = ubt_pkg::CNT_W;
  localparam logic [CW-1:0] LAST_STEP = CW'(VB - 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [VB-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [RW-1:0] dvs_r;

  logic [RW-1:0] sh;
  logic          ge;
  logic [RW-1:0] diff;

  // remainder stays below the divisor (at most 16), so it fits in a digit
  always_comb begin
    sh   = {rem_r, q_r[VB-1]};
    ge   = (sh >= dvs_r);
    diff = sh - dvs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[VB-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : sh[DW-1:0];
    end
  end

  assign res.done = done_r;
  assign res.quot = q_r;
  assign res.rem  = rem_r;

endmodule

>>> hdl/ubt_front.sv
// Front end: masks the value to its mode's width and classifies each request.
module ubt_front #(
  parameter int MAX_RADIX     = 16,
  parameter int POINTER_BITS  = 48,
  parameter int UNSIGNED_BITS = 32
) (
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ubt_pkg::VALUE_BITS-1:0]     in_value,
  input  logic                               in_operation,
  input  logic [ubt_pkg::RADIX_W-1:0]        radix,
  input  logic                               q_full,
  output logic                               q_push,
  output ubt_pkg::ubt_entry_t                q_entry
);

  localparam int VB = ubt_pkg::VALUE_BITS;
  localparam int RW = ubt_pkg::RADIX_W;
  localparam logic [63:0]   PTR_M64  = (64'd1 << POINTER_BITS) - 64'd1;
  localparam logic [63:0]   UNS_M64  = (64'd1 << UNSIGNED_BITS) - 64'd1;
  localparam logic [VB-1:0] PTR_MASK = PTR_M64[VB-1:0];
  localparam logic [VB-1:0] UNS_MASK = UNS_M64[VB-1:0];
  localparam logic [RW-1:0] MAX_R    = RW'(MAX_RADIX);

  logic [VB-1:0] masked;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    masked        = in_value & (in_operation ? PTR_MASK : UNS_MASK);
    q_entry.ptr   = in_operation;
    q_entry.value = masked;
    q_entry.radix = (radix > MAX_R) ? MAX_R : radix;
    // zero is decided before the radix check
    if (masked == '0) begin
      q_entry.kind = in_operation ? ubt_pkg::K_NIL : ubt_pkg::K_ZERO;
    end else if (radix < ubt_pkg::MIN_RADIX) begin
      q_entry.kind = ubt_pkg::K_BAD;
    end else begin
      q_entry.kind = ubt_pkg::K_CONV;
    end
  end

endmodule

>>> hdl/ubt_back.sv
// Back end: runs the divider per digit, stores digits, emits the text.
module ubt_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  ubt_pkg::ubt_entry_t             q_data,
  output logic                            q_pop,
  output ubt_pkg::ubt_div_req_t           div_req,
  input  ubt_pkg::ubt_div_res_t           div_res,
  input  logic [ubt_pkg::ALPHA_W-1:0]     alphabet,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ubt_pkg::CHAR_W-1:0]      out_text_char,
  output logic                            out_last_char,
  output logic                            out_bad_radix
);

  localparam int VB = ubt_pkg::VALUE_BITS;
  localparam int DW = ubt_pkg::DIGIT_W;
  localparam int CW = ubt_pkg::CNT_W;
  localparam int TW = ubt_pkg::TIDX_W;
  localparam int HW = ubt_pkg::CHAR_W;

  ubt_pkg::ubt_bstate_t state_r, state_nxt;
  ubt_pkg::ubt_entry_t  ent_r, ent_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [TW-1:0]        tidx_r, tidx_nxt;

  logic                 out_valid_r;
  logic [HW-1:0]        char_r;
  logic                 last_r;
  logic                 bad_r;

  logic                 can_load;
  logic                 load;
  logic [HW-1:0]        ld_char;
  logic                 ld_last;
  logic                 ld_bad;
  logic                 mem_we;
  logic                 mem_re;
  logic [CW-1:0]        raddr;

  logic [DW-1:0]        digit_mem [VB];
  logic [DW-1:0]        rd_data_r;

  assign can_load = !out_valid_r || !out_stall;
  assign raddr    = idx_r - CW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[idx_r] <= div_res.rem;
    end
    if (mem_re) begin
      rd_data_r <= digit_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ubt_pkg::B_IDLE;
      idx_r   <= '0;
      tidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      tidx_r  <= tidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    ent_nxt          = ent_r;
    idx_nxt          = idx_r;
    tidx_nxt         = tidx_r;
    q_pop            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = div_res.quot;
    div_req.divisor  = ent_r.radix;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    load             = 1'b0;
    ld_char          = ubt_pkg::CH_NUL;
    ld_last          = 1'b0;
    ld_bad           = 1'b0;
    case (state_r)
      ubt_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          ent_nxt  = q_data;
          idx_nxt  = '0;
          tidx_nxt = '0;
          if (q_data.kind == ubt_pkg::K_CONV) begin
            div_req.start    = 1'b1;
            div_req.dividend = q_data.value;
            div_req.divisor  = q_data.radix;
            state_nxt        = ubt_pkg::B_DIV;
          end else begin
            state_nxt = ubt_pkg::B_TEXT;
          end
        end
      end
      ubt_pkg::B_TEXT: begin
        if (can_load) begin
          load    = 1'b1;
          ld_char = ubt_pkg::fixed_char(ent_r.kind, tidx_r);
          ld_last = ubt_pkg::fixed_last(ent_r.kind, tidx_r);
          ld_bad  = (ent_r.kind == ubt_pkg::K_BAD);
          if (ld_last) begin
            state_nxt = ubt_pkg::B_IDLE;
          end else begin
            tidx_nxt = tidx_r + TW'(1);
          end
        end
      end
      ubt_pkg::B_DIV: begin
        if (div_res.done) begin
          mem_we  = 1'b1;
          idx_nxt = idx_r + CW'(1);
          if (div_res.quot != '0) begin
            div_req.start = 1'b1;
          end else begin
            tidx_nxt  = '0;
            state_nxt = ent_r.ptr ? ubt_pkg::B_PFX : ubt_pkg::B_RD;
          end
        end
      end
      ubt_pkg::B_PFX: begin
        if (can_load) begin
          load    = 1'b1;
          ld_char = (tidx_r == '0) ? ubt_pkg::CH_ZERO : ubt_pkg::CH_X;
          if (tidx_r == ubt_pkg::PFX_LAST) begin
            state_nxt = ubt_pkg::B_RD;
          end else begin
            tidx_nxt = tidx_r + TW'(1);
          end
        end
      end
      ubt_pkg::B_RD: begin
        mem_re    = 1'b1;
        idx_nxt   = raddr;
        state_nxt = ubt_pkg::B_OUT;
      end
      ubt_pkg::B_OUT: begin
        if (can_load) begin
          load    = 1'b1;
          ld_char = alphabet[{rd_data_r, 3'b000} +: HW];
          ld_last = (idx_r == '0);
          state_nxt = ld_last ? ubt_pkg::B_IDLE : ubt_pkg::B_RD;
        end
      end
      default: begin
        state_nxt = ubt_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= ld_char;
      last_r <= ld_last;
      bad_r  <= ld_bad;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = char_r;
  assign out_last_char = last_r;
  assign out_bad_radix = bad_r;

endmodule

>>> hdl/unsigned_to_base_text_core.sv
// Unsigned value to radix text converter, top level.
// Flow: the divider produces each digit from a full bit-serial pass, up to 48 digits; each
//   digit character then takes a read state and an output state, after "0x" for pointers;
//   zero, "(nil)" and bad radix go out one character a cycle while out_stall is low.
//   Throughput: one request at a time in the back end, up to two more waiting in the queue.
// Reset: synchronous, active low; radix and alphabet clear, so nonzero values report bad radix.
module unsigned_to_base_text_core #(
  parameter int MAX_RADIX     = 16,
  parameter int POINTER_BITS  = 48,
  parameter int UNSIGNED_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ubt_pkg::VALUE_BITS-1:0]  in_value,
  input  logic                            in_operation,
  // character channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ubt_pkg::CHAR_W-1:0]      out_text_char,
  output logic                            out_last_char,
  output logic                            out_bad_radix,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ubt_pkg::ADDR_W-1:0]      paddr,
  input  logic [ubt_pkg::DATA_W-1:0]      pwdata,
  output logic [ubt_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  localparam int RW = ubt_pkg::RADIX_W;
  localparam int DW = ubt_pkg::DATA_W;

  // configuration registers
  logic [RW-1:0]        radix_r;
  logic [DW-1:0]        chars_lo_r;
  logic [DW-1:0]        chars_hi_r;
  logic                 cfg_wr;
  logic [1:0]           cfg_sel;

  // front to queue
  logic                 q_push;
  logic                 q_full;
  ubt_pkg::ubt_entry_t  q_entry;

  // queue to back
  logic                 q_pop;
  logic                 q_nonempty;
  ubt_pkg::ubt_entry_t  q_head;

  // back to divider
  ubt_pkg::ubt_div_req_t div_req;
  ubt_pkg::ubt_div_res_t div_res;

  // registers are 64 bits wide, so they sit on 8-byte boundaries
  assign pready  = 1'b1;
  assign cfg_sel = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= '0;
      chars_lo_r <= '0;
      chars_hi_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        ubt_pkg::REG_RADIX:    radix_r    <= pwdata[RW-1:0];
        ubt_pkg::REG_CHARS_LO: chars_lo_r <= pwdata;
        ubt_pkg::REG_CHARS_HI: chars_hi_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      ubt_pkg::REG_RADIX:    prdata = {{(DW-RW){1'b0}}, radix_r};
      ubt_pkg::REG_CHARS_LO: prdata = chars_lo_r;
      ubt_pkg::REG_CHARS_HI: prdata = chars_hi_r;
      default:               prdata = '0;
    endcase
  end

  // front: mask, classify (zero / nil / bad radix / convert), saturate radix
  ubt_front #(
    .MAX_RADIX     (MAX_RADIX),
    .POINTER_BITS  (POINTER_BITS),
    .UNSIGNED_BITS (UNSIGNED_BITS)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_operation (in_operation),
    .radix        (radix_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  // short queue so the front keeps taking requests while the back converts
  ubt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .din      (q_entry),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .dout     (q_head)
  );

  // bit-serial divider, used by the back end: one digit per VALUE_BITS steps
  ubt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // back: digit loop, digit store, reversed emission through the output register
  ubt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_nonempty),
    .q_data        (q_head),
    .q_pop         (q_pop),
    .div_req       (div_req),
    .div_res       (div_res),
    .alphabet      ({chars_hi_r, chars_lo_r}),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char),
    .out_bad_radix (out_bad_radix)
  );

  // the error result is a single NUL character that closes its text
  a_bad_is_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_radix |-> out_last_char && (out_text_char == ubt_pkg::CH_NUL))
    else $error("bad-radix result not a lone terminating NUL");

  // a conversion request only enters the queue with a usable radix and a nonzero value
  a_conv_radix : assert property (@(posedge clk) disable iff (!rst_n)
    q_push && (q_entry.kind == ubt_pkg::K_CONV) |->
      (q_entry.radix >= ubt_pkg::MIN_RADIX) && (q_entry.value != '0))
    else $error("conversion queued with unusable radix or zero value");

  // a radix write lands in the register
  a_radix_write : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_sel == ubt_pkg::REG_RADIX) |=> radix_r == $past(pwdata[RW-1:0]))
    else $error("radix register write lost");

  // the queue never pops while empty
  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nonempty)
    else $error("queue popped while empty");

endmodule
